// File: src/ucrs_pkg.sv
// Shared types and constants for the unit cube slab test.
// Holds the payload structs, fixed-point constants and pipeline depths.
// No dependencies.
package ucrs_pkg;

  // Quotient bits resolved by the divider, one per pipeline stage.
  localparam int QW = 33;

  // Divider: operand register, QW step stages, result register.
  localparam int DIV_LAT = QW + 2;

  // Axis lane: divider plus the ordering register.
  localparam int AXIS_LAT = DIV_LAT + 1;

  // Whole pipeline: axis lanes plus the merge register.
  localparam int PIPE_LAT = AXIS_LAT + 1;

  localparam logic signed [17:0] ONE_Q12 = 18'sd4096;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic        [15:0] object_tag;
  } ray_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
    logic        [15:0] tag_out;
  } ray_out_t;

  // Ordered slab interval of one axis.
  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } slab_t;

endpackage

// File: src/ucrs_div.sv
// Pipelined signed divider: (num * 65536) / den, truncated, saturated to 32 bits.
// Restoring division on magnitudes, one quotient bit per stage.
// Depends on ucrs_pkg.
module ucrs_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [17:0] num,
  input  logic signed [15:0] den,
  output logic signed [31:0] quot
);

  localparam int QW = ucrs_pkg::QW;

  logic [17:0]   num_abs;
  logic [15:0]   den_abs;

  logic [16:0]   rem    [QW+1];
  logic [QW-1:0] dq     [QW+1];
  logic [15:0]   dv     [QW+1];
  logic          neg    [QW+1];
  logic          dz     [QW+1];
  logic          npos   [QW+1];
  logic          nneg   [QW+1];

  logic [16:0]   sh     [QW];
  logic          ge     [QW];
  logic [16:0]   rem_n  [QW];

  logic [QW-1:0] qmag;
  logic [31:0]   qneg;

  assign num_abs = num[17] ? (~num + 18'd1) : num;
  assign den_abs = den[15] ? (~den + 16'd1) : den;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      sh[k]    = {rem[k][15:0], dq[k][QW-1]};
      ge[k]    = (sh[k] >= {1'b0, dv[k]});
      rem_n[k] = ge[k] ? (sh[k] - {1'b0, dv[k]}) : sh[k];
    end
  end

  assign qmag = dq[QW];
  assign qneg = ~qmag[31:0] + 32'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      dq[0]   <= {num_abs[16:0], 16'd0};
      dv[0]   <= den_abs;
      neg[0]  <= num[17] ^ den[15];
      dz[0]   <= (den == 16'sd0);
      npos[0] <= !num[17] && (num != 18'sd0);
      nneg[0] <= num[17];
      for (int k = 0; k < QW; k++) begin
        rem[k+1]  <= rem_n[k];
        dq[k+1]   <= {dq[k][QW-2:0], ge[k]};
        dv[k+1]   <= dv[k];
        neg[k+1]  <= neg[k];
        dz[k+1]   <= dz[k];
        npos[k+1] <= npos[k];
        nneg[k+1] <= nneg[k];
      end
      priority if (dz[QW]) begin
        quot <= npos[QW] ? ucrs_pkg::Q_MAX : (nneg[QW] ? ucrs_pkg::Q_MIN : 32'sd0);
      end else if (neg[QW]) begin
        quot <= (qmag > 33'h0_8000_0000) ? ucrs_pkg::Q_MIN : signed'(qneg);
      end else begin
        quot <= (qmag > 33'h0_7FFF_FFFF) ? ucrs_pkg::Q_MAX : signed'(qmag[31:0]);
      end
    end
  end

endmodule

// File: src/ucrs_axis.sv
// One axis lane: both slab distances through two dividers, then ordered.
// Depends on ucrs_pkg and ucrs_div.
module ucrs_axis (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [15:0]    orig,
  input  logic signed [15:0]    dir,
  output ucrs_pkg::slab_t       slab
);

  logic signed [17:0] o_ext;
  logic signed [17:0] num_lo;
  logic signed [17:0] num_hi;
  logic signed [31:0] qa;
  logic signed [31:0] qb;

  assign o_ext  = {{2{orig[15]}}, orig};
  assign num_lo = -ucrs_pkg::ONE_Q12 - o_ext;
  assign num_hi = ucrs_pkg::ONE_Q12 - o_ext;

  ucrs_div u_div_lo (.clk(clk), .en(en), .num(num_lo), .den(dir), .quot(qa));
  ucrs_div u_div_hi (.clk(clk), .en(en), .num(num_hi), .den(dir), .quot(qb));

  // Order the pair so lo holds the entry distance.
  always_ff @(posedge clk) begin
    if (en) begin
      if (qa > qb) begin
        slab.lo <= qb;
        slab.hi <= qa;
      end else begin
        slab.lo <= qa;
        slab.hi <= qb;
      end
    end
  end

endmodule

// File: src/ucrs_merge.sv
// Merge stage: largest entry and smallest exit over three axes, hit test.
// Depends on ucrs_pkg.
module ucrs_merge (
  input  logic                clk,
  input  logic                en,
  input  ucrs_pkg::slab_t     slab_x,
  input  ucrs_pkg::slab_t     slab_y,
  input  ucrs_pkg::slab_t     slab_z,
  input  logic [15:0]         tag,
  output ucrs_pkg::ray_out_t  res
);

  logic signed [31:0] near_xy;
  logic signed [31:0] far_xy;
  logic signed [31:0] t_near;
  logic signed [31:0] t_far;
  logic               hit;

  assign near_xy = (slab_y.lo > slab_x.lo) ? slab_y.lo : slab_x.lo;
  assign far_xy  = (slab_y.hi < slab_x.hi) ? slab_y.hi : slab_x.hi;
  assign t_near  = (slab_z.lo > near_xy) ? slab_z.lo : near_xy;
  assign t_far   = (slab_z.hi < far_xy) ? slab_z.hi : far_xy;
  assign hit     = (t_near <= t_far);

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit     <= hit;
      res.t_near  <= hit ? t_near : 32'sd0;
      res.t_far   <= hit ? t_far : 32'sd0;
      res.tag_out <= tag;
    end
  end

endmodule

// File: src/unit_cube_ray_slab_test.sv
// Ray versus unit cube (-1..+1 on every axis) slab test, fully pipelined.
// Depends on ucrs_pkg, ucrs_axis and ucrs_merge.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one ray per
//   transaction: origin and direction per axis in signed Q4.12 plus a tag.
//   Output channel (out_valid / out_stall / out_data) returns one result
//   per ray, in order: hit flag, t_near and t_far in signed Q16.16
//   (saturated, both zero on a miss) and the tag copied through.
// Throughput: one transaction per cycle while no held result is stalled.
//   Three axis lanes run side by side, each with two pipelined dividers
//   resolving one quotient bit per stage; a merge stage combines the lanes.
// Pipeline from acceptance to out_valid: operand register, 33 divider
//   steps, quotient fixup, axis ordering, merge/output register.
// Stall: the whole pipeline holds while a result waits and out_stall is
//   high; in_stall is raised in exactly those cycles. The last stage is the
//   output register, so a new ray is taken whenever the result is taken.
// Reset: rst (synchronous, active high) clears all valid bits; in-flight
//   transactions are dropped. Payload registers are not reset.
module unit_cube_ray_slab_test (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ucrs_pkg::ray_in_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ucrs_pkg::ray_out_t  out_data
);

  localparam int PL = ucrs_pkg::PIPE_LAT;
  localparam int AL = ucrs_pkg::AXIS_LAT;

  logic            en;
  logic [PL-1:0]   vld;
  logic [15:0]     tag_line [AL];
  ucrs_pkg::slab_t slab_x;
  ucrs_pkg::slab_t slab_y;
  ucrs_pkg::slab_t slab_z;

  // Advance the whole pipeline unless a finished result is held.
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[PL-1];

  // Valid bits ride alongside the data; bubbles pass as invalid entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PL-2:0], in_valid};
    end
  end

  // Tag delay line matched to the axis lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      tag_line[0] <= in_data.object_tag;
      for (int k = 1; k < AL; k++) begin
        tag_line[k] <= tag_line[k-1];
      end
    end
  end

  ucrs_axis u_axis_x (
    .clk(clk), .en(en), .orig(in_data.origin_x), .dir(in_data.dir_x), .slab(slab_x)
  );
  ucrs_axis u_axis_y (
    .clk(clk), .en(en), .orig(in_data.origin_y), .dir(in_data.dir_y), .slab(slab_y)
  );
  ucrs_axis u_axis_z (
    .clk(clk), .en(en), .orig(in_data.origin_z), .dir(in_data.dir_z), .slab(slab_z)
  );

  // Merge register doubles as the output register.
  ucrs_merge u_merge (
    .clk(clk), .en(en), .slab_x(slab_x), .slab_y(slab_y), .slab_z(slab_z),
    .tag(tag_line[AL-1]), .res(out_data)
  );

endmodule

// File: src/ucrs_checker.sv
// Port-level checker for the unit cube slab test, bound to the top level.
// Depends on ucrs_pkg.
module ucrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input ucrs_pkg::ray_out_t out_data,
  input logic               out_valid,
  input logic               out_stall
);

  // Held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Input backpressure comes only from a held result.
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output hold");

  // A miss reports zero distances.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.t_near == 32'sd0 && out_data.t_far == 32'sd0)
    else $error("miss with nonzero distance");

  // A hit has an ordered interval.
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.t_near <= out_data.t_far)
    else $error("hit with entry after exit");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind unit_cube_ray_slab_test ucrs_checker u_ucrs_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);
